// File: hw/rtl/bounded_lifo_stack_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded LIFO stack
// Shared concurrent checks, sampled on the rising clock edge and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIFO_STACK_ASSERT_SVH
`define BOUNDED_LIFO_STACK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_lifo_stack: check failed");

// Consequent must hold in the cycle after the antecedent.
`define BLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_lifo_stack: check failed");

`endif

// File: hw/rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Sizes, command and status codes, and the control interface between the
// stack controller and its datapath.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int DEPTH   = 8;
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DFT_W   = 4;
  localparam int CMP_W   = (OCC_W > DFT_W) ? OCC_W : DFT_W;
  localparam int WORD_W  = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_UPDATE  = 3'd3,
    CMD_DISPLAY = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_DEPTH = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    push;       // write value at top, grow by one
    logic    pop;        // shrink by one
    logic    rd_top;     // read top entry, load display pointer
    logic    upd;        // write value at depth_from_top
    logic    disp_next;  // step display pointer down and read
    logic    load_out;   // load the result register
    status_t out_status;
    logic    out_mem;    // result data comes from the read register
    logic    out_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic depth_ok;
    logic ptr_zero;
    logic out_valid;
  } dp_stat_t;

endpackage

// File: hw/rtl/bls_ctrl.sv
// ----------------------------------------------------------------------------
// bls_ctrl
// Command decoder and sequencer: takes one command, issues the store access,
// then loads one result or streams a display run, or drops an undefined one.
// ----------------------------------------------------------------------------
`include "bounded_lifo_stack_assert.svh"

module bls_ctrl import bls_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] command,
  input  logic             out_stall,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EMIT = 3'b010,
    S_DISP = 3'b100
  } state_t;

  state_t  state, state_next;
  status_t res_status, res_status_next;
  logic    res_mem, res_mem_next;
  logic    out_free;

  assign out_free = !stat.out_valid || !out_stall;

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_mem_next    = res_mem;
    in_stall        = 1'b1;
    cmd             = '0;
    cmd.out_status  = ST_OK;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          res_mem_next    = 1'b0;
          res_status_next = ST_OK;
          case (command)
            CMD_PUSH: begin
              state_next = S_EMIT;
              if (stat.full) begin
                res_status_next = ST_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
              end
            end
            CMD_POP: begin
              state_next = S_EMIT;
              if (stat.empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                cmd.pop      = 1'b1;
                cmd.rd_top   = 1'b1;
                res_mem_next = 1'b1;
              end
            end
            CMD_PEEK: begin
              state_next = S_EMIT;
              if (stat.empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                cmd.rd_top   = 1'b1;
                res_mem_next = 1'b1;
              end
            end
            CMD_UPDATE: begin
              state_next = S_EMIT;
              if (stat.depth_ok) begin
                cmd.upd = 1'b1;
              end else begin
                res_status_next = ST_BAD_DEPTH;
              end
            end
            CMD_DISPLAY: begin
              if (stat.empty) begin
                state_next      = S_EMIT;
                res_status_next = ST_EMPTY;
              end else begin
                cmd.rd_top = 1'b1;
                state_next = S_DISP;
              end
            end
            default: begin
              // undefined command: drop the transaction
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_status = res_status;
          cmd.out_mem    = res_mem;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DISP: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_mem    = 1'b1;
          cmd.out_last   = stat.ptr_zero;
          if (stat.ptr_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.disp_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_mem    <= res_mem_next;
  end

  `BLS_ASSERT_NOW(a_load_only_when_free, clk, rst, cmd.load_out, out_free)
  `BLS_ASSERT_NOW(a_one_store_op, clk, rst, 1'b1,
                  $onehot0({cmd.push, cmd.upd, cmd.rd_top, cmd.disp_next}))
  `BLS_ASSERT_NEXT(a_disp_ends_idle, clk, rst,
                   (state == S_DISP) && cmd.load_out && stat.ptr_zero,
                   (state == S_IDLE))

endmodule

// File: hw/rtl/bls_dpath.sv
// ----------------------------------------------------------------------------
// bls_dpath
// Word store, occupancy count, display pointer and the result register.
// ----------------------------------------------------------------------------
`include "bounded_lifo_stack_assert.svh"

module bls_dpath import bls_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic signed [WORD_W-1:0] value,
  input  logic [DFT_W-1:0]         depth_from_top,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        status,
  output logic signed [WORD_W-1:0] data,
  output logic                     last
);

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data;
  logic [OCC_W-1:0]         occ;
  logic [OCC_W-1:0]         occ_dec;
  logic [IDX_W-1:0]         ptr;
  logic [IDX_W-1:0]         top_idx;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         upd_addr;
  logic [CMP_W-1:0]         occ_ext;
  logic [CMP_W-1:0]         dft_ext;
  logic [CMP_W-1:0]         upd_diff;
  logic                     rd_en;

  assign occ_dec  = occ - OCC_W'(1);
  assign top_idx  = occ_dec[IDX_W-1:0];
  assign occ_ext  = CMP_W'(occ);
  assign dft_ext  = CMP_W'(depth_from_top);
  assign upd_diff = occ_ext - dft_ext;
  assign upd_addr = upd_diff[IDX_W-1:0];
  assign rd_en    = cmd.rd_top || cmd.disp_next;
  assign rd_addr  = cmd.disp_next ? (ptr - IDX_W'(1)) : top_idx;

  assign stat.empty     = (occ == '0);
  assign stat.full      = (occ == OCC_W'(DEPTH));
  assign stat.depth_ok  = (dft_ext != '0) && (dft_ext <= occ_ext);
  assign stat.ptr_zero  = (ptr == '0);
  assign stat.out_valid = out_valid;

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[occ[IDX_W-1:0]] <= value;
    end else if (cmd.upd) begin
      mem[upd_addr] <= value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.push) begin
      occ <= occ + OCC_W'(1);
    end else if (cmd.pop) begin
      occ <= occ_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_top) begin
      ptr <= top_idx;
    end else if (cmd.disp_next) begin
      ptr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= cmd.out_status;
      data   <= cmd.out_mem ? rd_data : '0;
      last   <= cmd.out_last;
    end
  end

  `BLS_ASSERT_NOW(a_occ_bound, clk, rst, 1'b1, (occ <= OCC_W'(DEPTH)))
  `BLS_ASSERT_NOW(a_no_push_full, clk, rst, cmd.push, !stat.full)
  `BLS_ASSERT_NEXT(a_push_grows, clk, rst, cmd.push, (occ == $past(occ) + OCC_W'(1)))

endmodule

// File: hw/rtl/bounded_lifo_stack.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack of signed 32-bit words driven by one command per
// transaction.
// ----------------------------------------------------------------------------
// Each accepted command is worked one at a time. Push, pop, peek and update
// do the store access on accept; S_EMIT then loads the result register once
// the output is free. Display reads the top entry on accept, then streams
// entries top to bottom at one entry per cycle unless the output stalls,
// through the store's single read port; an empty display gives one empty
// status. An undefined command is dropped, with no result. A new command is
// accepted while an earlier result still waits in the output register;
// output stall holds the sequencer. The store needs no clearing after reset.

module bounded_lifo_stack import bls_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [WORD_W-1:0] value,
  input  logic [DFT_W-1:0]         depth_from_top,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        status,
  output logic signed [WORD_W-1:0] data,
  output logic                     last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bls_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .value          (value),
    .depth_from_top (depth_from_top),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .data           (data),
    .last           (last)
  );

endmodule
